// ----- sv/first_fit_heap_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_defines.svh
// Assertion macros shared by the checker of the heap allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and fixed field widths of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Request and result field widths.
  localparam int REQ_W      = 14;
  localparam int FADDR_W    = 13;
  localparam int RES_ADDR_W = 13;
  localparam int NEED_W     = 15;
  localparam int STATUS_W   = 2;

  // Stream bus widths.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffha_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NOFIT   = 2'd2,
    STAT_BADADDR = 2'd3
  } ffha_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ALIGN,
    S_RD,
    S_CHK,
    S_ABS_RD,
    S_ABS_CHK,
    S_MERGE,
    S_SPLIT,
    S_DONE
  } ffha_state_t;

endpackage

// ----- sv/ffha_hdr_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Block header store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffha_hdr_ram #(
  parameter int DEPTH  = 8192,
  parameter int DATA_W = 14
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap manager that walks block headers kept in an on-chip store.
// ----------------------------------------------------------------------------
// Usage: a request enters on the in_ stream (tuser = operation, tdata =
// size and release offset) and exactly one result leaves on the out_ stream
// (tuser = status, tdata = payload offset). Requests are handled one at a
// time; in_tready is high only while the sequencer waits for work.
// Sequence: an allocate first rounds the size (a multiply by the constant
// reciprocal of the alignment, then a multiply back by the alignment),
// then reads block headers one at a time while walking and coalescing,
// writes back the header it settles on, and a second one when it splits
// a block, and loads the result register. A free walks the same way
// without the rounding. A zero-size allocate goes straight to the result
// register. The header walk through the single read port of the header
// store sets how long a request takes.
// Reset: rst_n is synchronous and active low. After reset the INIT state
// writes the single free block that spans the heap; in_tready stays low
// in that state.
// Stall: the result sits in an output register. While the receiver holds
// out_tready low, the sequencer finishes the next request and then waits
// with its result until the register frees up.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES      = 8192,
  parameter int ALIGN_BYTES     = 8,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_SPLIT_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ffha_pkg::IN_TDATA_W-1:0]  in_tdata,   // req_size[13:0], free_addr[26:14]
  input  logic                             in_tuser,   // op
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ffha_pkg::OUT_TDATA_W-1:0] out_tdata,  // addr[12:0]
  output logic [ffha_pkg::STATUS_W-1:0]    out_tuser   // status
);

  import ffha_pkg::*;

  // Block bases lie below HEAP_BYTES; arithmetic runs at a width that also
  // holds the rounded request size.
  localparam int PTR_W = $clog2(HEAP_BYTES);
  localparam int W     = (PTR_W + 1 > NEED_W) ? PTR_W + 1 : NEED_W;
  localparam int HDR_DW = PTR_W + 1;

  // Division by the alignment uses a constant reciprocal that is exact for
  // every dividend below 2**NEED_W.
  localparam int AL_S  = NEED_W + $clog2(ALIGN_BYTES);
  localparam int AL_PW = NEED_W + AL_S + 1;
  localparam logic [AL_PW-1:0] AL_M =
    AL_PW'(((64'd1 << AL_S) + ALIGN_BYTES - 1) / ALIGN_BYTES);

  localparam logic [W-1:0] HDR_C  = W'(HEADER_BYTES);
  localparam logic [W-1:0] HEAP_C = W'(HEAP_BYTES);
  localparam logic [W-1:0] MINS_C = W'(MIN_SPLIT_BYTES);

  ffha_state_t state_r, state_nxt;

  // Request registers.
  ffha_op_t             op_r, op_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [FADDR_W-1:0]   faddr_r, faddr_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  logic                 align_ph_r, align_ph_nxt;

  // Walk registers: current header, head of a coalescing run and its capacity.
  logic [PTR_W-1:0]     cur_r, cur_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     acc_r, acc_nxt;

  // Pending result and output register.
  logic [RES_ADDR_W-1:0] res_addr_r, res_addr_nxt;
  ffha_status_t          res_stat_r, res_stat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RES_ADDR_W-1:0] out_addr_r, out_addr_nxt;
  ffha_status_t          out_stat_r, out_stat_nxt;

  // Header store port.
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [HDR_DW-1:0] mem_wdata;
  logic [PTR_W-1:0]  mem_raddr;
  logic [HDR_DW-1:0] mem_rdata;

  ffha_hdr_ram #(
    .DEPTH  (HEAP_BYTES),
    .DATA_W (HDR_DW)
  ) u_hdr_ram (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr   (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  // A header holds the used flag above the payload capacity.
  logic             rd_used;
  logic [PTR_W-1:0] rd_cap;
  assign rd_used = mem_rdata[PTR_W];
  assign rd_cap  = mem_rdata[PTR_W-1:0];

  // Datapath terms.
  logic [W-1:0]      pay_cur, chk_next, head_pay, abs_nxt, acc_ext, need_ext, rem_fit;
  logic [W-1:0]      faddr_ext, merged;
  logic              fit, split, out_free;
  logic              accept;
  logic [NEED_W-1:0] req_up;
  logic [AL_PW-1:0]  quot_prod;

  assign accept    = in_tvalid && in_tready;
  assign pay_cur   = W'(cur_r) + HDR_C;
  assign chk_next  = pay_cur + W'(rd_cap);
  assign head_pay  = W'(head_r) + HDR_C;
  assign abs_nxt   = head_pay + W'(acc_r);
  assign acc_ext   = W'(acc_r);
  assign need_ext  = W'(need_r);
  assign fit       = acc_ext >= need_ext;
  assign rem_fit   = acc_ext - need_ext;
  assign split     = fit && (rem_fit >= MINS_C) && (rem_fit >= HDR_C);
  assign faddr_ext = W'(faddr_r);
  assign merged    = acc_ext + HDR_C + W'(rd_cap);
  assign out_free  = !out_valid_r || out_tready;
  assign req_up    = NEED_W'(req_r) + NEED_W'(ALIGN_BYTES - 1);
  assign quot_prod = AL_PW'(req_up) * AL_M;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (ffha_op_t'(in_tuser) == OP_FREE) begin
            state_nxt = S_RD;
          end else if (in_tdata[REQ_W-1:0] == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ALIGN;
          end
        end
      end
      S_ALIGN: begin
        if (!align_ph_r) begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (op_r == OP_ALLOC) begin
          if (!rd_used) begin
            state_nxt = S_ABS_RD;
          end else if (chk_next >= HEAP_C) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          if (pay_cur == faddr_ext) begin
            state_nxt = rd_used ? S_ABS_RD : S_DONE;
          end else if (pay_cur > faddr_ext || chk_next >= HEAP_C) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_ABS_RD: state_nxt = (abs_nxt >= HEAP_C) ? S_MERGE : S_ABS_CHK;
      S_ABS_CHK: state_nxt = rd_used ? S_MERGE : S_ABS_RD;
      S_MERGE: begin
        if (op_r == OP_FREE) begin
          state_nxt = S_DONE;
        end else if (split) begin
          state_nxt = S_SPLIT;
        end else if (fit || abs_nxt >= HEAP_C) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_SPLIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Datapath, header store and result register controls.
  always_comb begin
    op_nxt       = op_r;
    req_nxt      = req_r;
    faddr_nxt    = faddr_r;
    need_nxt     = need_r;
    align_ph_nxt = align_ph_r;
    cur_nxt      = cur_r;
    head_nxt     = head_r;
    acc_nxt      = acc_r;
    res_addr_nxt = res_addr_r;
    res_stat_nxt = res_stat_r;
    out_addr_nxt = out_addr_r;
    out_stat_nxt = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we       = 1'b0;
    mem_waddr    = head_r;
    mem_wdata    = {1'b0, acc_r};
    mem_raddr    = (state_r == S_ABS_RD) ? PTR_W'(abs_nxt) : cur_r;

    unique case (state_r)
      S_INIT: begin
        // One free block spans the whole heap.
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {1'b0, PTR_W'(HEAP_C - HDR_C)};
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt       = ffha_op_t'(in_tuser);
          req_nxt      = in_tdata[REQ_W-1:0];
          faddr_nxt    = in_tdata[REQ_W +: FADDR_W];
          cur_nxt      = '0;
          align_ph_nxt = 1'b1;
          res_addr_nxt = '0;
          res_stat_nxt = STAT_ZERO;
        end
      end
      S_ALIGN: begin
        if (align_ph_r) begin
          // Number of alignment units, rounded up.
          need_nxt     = quot_prod[AL_S +: NEED_W];
          align_ph_nxt = 1'b0;
        end else begin
          need_nxt = NEED_W'(need_r * NEED_W'(ALIGN_BYTES));
        end
      end
      S_RD: ;
      S_CHK: begin
        head_nxt = cur_r;
        acc_nxt  = rd_cap;
        cur_nxt  = PTR_W'(chk_next);
        res_addr_nxt = '0;
        res_stat_nxt = (op_r == OP_ALLOC) ? STAT_NOFIT : STAT_BADADDR;
      end
      S_ABS_RD: ;
      S_ABS_CHK: begin
        if (!rd_used) begin
          acc_nxt = PTR_W'(merged);
        end
      end
      S_MERGE: begin
        mem_we = 1'b1;
        cur_nxt = PTR_W'(abs_nxt);
        if (op_r == OP_FREE) begin
          mem_wdata    = {1'b0, acc_r};
          res_addr_nxt = faddr_r;
          res_stat_nxt = STAT_OK;
        end else if (fit) begin
          mem_wdata    = split ? {1'b1, PTR_W'(need_r)} : {1'b1, acc_r};
          res_addr_nxt = RES_ADDR_W'(head_pay);
          res_stat_nxt = STAT_OK;
        end else begin
          // Coalescing done on the way stays, even without a fit.
          mem_wdata    = {1'b0, acc_r};
          res_addr_nxt = '0;
          res_stat_nxt = STAT_NOFIT;
        end
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = PTR_W'(head_pay + need_ext);
        mem_wdata = {1'b0, PTR_W'(rem_fit - HDR_C)};
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_stat_nxt  = res_stat_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    faddr_r    <= faddr_nxt;
    need_r     <= need_nxt;
    align_ph_r <= align_ph_nxt;
    cur_r      <= cur_nxt;
    head_r     <= head_nxt;
    acc_r      <= acc_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_addr_r);
  assign out_tuser  = out_stat_r;

endmodule

// ----- sv/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the heap allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ffha_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ffha_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ffha_pkg::STATUS_W-1:0]    out_tuser
);

  import ffha_pkg::*;

  // A stalled result keeps its contents.
  `FFHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Any error result carries a zero offset.
  `FFHA_ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && out_tuser != STAT_OK, out_tdata == '0, "error result with nonzero offset")

  // Requests are handled one at a time.
  `FFHA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready stayed high after a request was taken")

  // The header store is written before the first request is taken.
  `FFHA_ASSERT_NOW(a_init_busy, clk, rst_n, $rose(rst_n), !in_tready && !out_tvalid, "ready or result right after reset")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/tb_first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// A short directed run covers zero-size and oversized allocations, an exact
// fit of the whole heap, a small leftover that is not split, a double free,
// bad offsets and a free next to a free block that lies before it.
// A long random run follows. Most of it is allocate/free traffic on offsets
// that are really live, mixed with stray frees. A software copy of the block
// list predicts every reply, and each reply from the block is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
import ffha_pkg::*;

typedef struct packed {
  logic [RES_ADDR_W-1:0] addr;
  ffha_status_t          status;
} heap_reply_t;

class heap_tracker;
  localparam int unsigned HEAP_BYTES      = 8192;
  localparam int unsigned ALIGN_BYTES     = 8;
  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned MIN_SPLIT_BYTES = 32;
  localparam int unsigned MAX_BLOCKS      = HEAP_BYTES / HEADER_BYTES + 1;

  // Block list in address order: header offset, payload capacity, used flag.
  int unsigned blk_base [MAX_BLOCKS];
  int unsigned blk_cap  [MAX_BLOCKS];
  bit          blk_used [MAX_BLOCKS];
  int unsigned n_blocks;

  heap_reply_t replies_due[$];
  int unsigned live_offsets[$];
  int unsigned freed_offsets[$];
  int unsigned mismatches;
  int unsigned replies_seen;

  function new();
    n_blocks     = 1;
    blk_base[0]  = 0;
    blk_cap[0]   = HEAP_BYTES - HEADER_BYTES;
    blk_used[0]  = 1'b0;
    mismatches   = 0;
    replies_seen = 0;
  endfunction

  function void drop_block(int unsigned j);
    for (int unsigned k = j; k + 1 < n_blocks; k++) begin
      blk_base[k] = blk_base[k+1];
      blk_cap[k]  = blk_cap[k+1];
      blk_used[k] = blk_used[k+1];
    end
    n_blocks--;
  endfunction

  // Merge every free block that directly follows block i into it.
  function void absorb_after(int unsigned i);
    while (i + 1 < n_blocks && !blk_used[i+1]) begin
      blk_cap[i] += blk_cap[i+1] + HEADER_BYTES;
      drop_block(i + 1);
    end
  endfunction

  function void carve_block(int unsigned req, output heap_reply_t r);
    int unsigned need;
    int unsigned i;
    int unsigned rem;
    bit          found;
    found    = 1'b0;
    r.addr   = '0;
    r.status = STAT_ZERO;
    if (req == 0) return;
    need = (req + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    for (i = 0; i < n_blocks; i++) begin
      if (!blk_used[i]) begin
        absorb_after(i);
        if (blk_cap[i] >= need) begin
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) begin
      r.status = STAT_NOFIT;
      return;
    end
    rem = blk_cap[i] - need;
    if (rem >= MIN_SPLIT_BYTES && rem >= HEADER_BYTES && n_blocks < MAX_BLOCKS) begin
      for (int unsigned k = n_blocks; k > i + 1; k--) begin
        blk_base[k] = blk_base[k-1];
        blk_cap[k]  = blk_cap[k-1];
        blk_used[k] = blk_used[k-1];
      end
      blk_base[i+1] = blk_base[i] + HEADER_BYTES + need;
      blk_cap[i+1]  = rem - HEADER_BYTES;
      blk_used[i+1] = 1'b0;
      n_blocks++;
      blk_cap[i] = need;
    end
    blk_used[i] = 1'b1;
    r.addr   = RES_ADDR_W'(blk_base[i] + HEADER_BYTES);
    r.status = STAT_OK;
  endfunction

  function void release_block(int unsigned offset, output heap_reply_t r);
    int unsigned i;
    r.addr   = '0;
    r.status = STAT_BADADDR;
    for (i = 0; i < n_blocks; i++) begin
      if (blk_base[i] + HEADER_BYTES == offset) break;
    end
    if (i >= n_blocks) return;
    if (!blk_used[i]) return;
    blk_used[i] = 1'b0;
    absorb_after(i);
    r.addr   = RES_ADDR_W'(offset);
    r.status = STAT_OK;
  endfunction

  // Called once per accepted request, in acceptance order.
  function void note_request(ffha_op_t op, logic [REQ_W-1:0] size,
                             logic [FADDR_W-1:0] offset);
    heap_reply_t r;
    if (op == OP_ALLOC) begin
      carve_block(size, r);
      if (r.status == STAT_OK) live_offsets.push_back(r.addr);
    end else begin
      release_block(offset, r);
      if (r.status == STAT_OK) begin
        foreach (live_offsets[k]) begin
          if (live_offsets[k] == offset) begin
            live_offsets.delete(k);
            break;
          end
        end
        freed_offsets.push_back(offset);
        if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
      end
    end
    replies_due.push_back(r);
  endfunction

  task report(string msg);
    $display("[mismatch] %s", msg);
    mismatches++;
  endtask

  task check_result(logic [RES_ADDR_W-1:0] addr, logic [STATUS_W-1:0] status);
    heap_reply_t want;
    replies_seen++;
    if (replies_due.size() == 0) begin
      report($sformatf("reply %0d (addr %0d status %0d) with no request outstanding",
                       replies_seen, addr, status));
      return;
    end
    want = replies_due.pop_front();
    if (addr !== want.addr)
      report($sformatf("reply %0d addr %0d, predicted %0d", replies_seen, addr, want.addr));
    if (status !== want.status)
      report($sformatf("reply %0d status %0d, predicted %0d",
                       replies_seen, status, want.status));
  endtask

  function int unsigned pending();
    return replies_due.size();
  endfunction
endclass

module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_ITEMS    = 1600;
  // The receiver goes quiet once this many replies have arrived.
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned LONG_HOLD     = 400;
  // Quiet cycles after the last reply.
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef enum int unsigned {
    RX_OPEN,
    RX_HALF,
    RX_RARE_STALL,
    RX_SLOW
  } rx_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  heap_tracker ledger;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  first_fit_heap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Offer one request and hold it until the block takes it. The valid line is
  // left high so that a following request goes out back to back; only
  // pause_input and drain_results lower it. Must be called right after a
  // rising edge.
  task automatic send_request(ffha_op_t op, logic [REQ_W-1:0] size,
                              logic [FADDR_W-1:0] offset);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({offset, size});
    do @(posedge clk); while (!in_tready);
    ledger.note_request(op, size, offset);
  endtask

  task automatic pause_input(int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop offering requests until every predicted reply has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  // Choose the next random request. Most traffic allocates or frees offsets
  // that are live right now, so the block list grows, fragments and gets
  // coalesced. The rest are stray frees: offsets freed a moment ago (double
  // free), offsets a few words off a live block, or any offset at all.
  // Unused fields carry random values as well.
  function automatic void pick_request(output ffha_op_t op,
                                       output logic [REQ_W-1:0] size,
                                       output logic [FADDR_W-1:0] offset);
    int unsigned roll;
    int unsigned pick;
    int unsigned n_live;
    int unsigned n_freed;
    roll    = $urandom_range(0, 99);
    pick    = $urandom_range(0, 99);
    n_live  = ledger.live_offsets.size();
    n_freed = ledger.freed_offsets.size();
    op      = OP_FREE;
    size    = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
    offset  = FADDR_W'($urandom_range(0, (1 << FADDR_W) - 1));
    if (roll < 48) begin
      op = OP_ALLOC;
      // Mostly small sizes keep the walks short; a few large and oversized
      // ones reach the no-fit path and the top size bit.
      if (pick < 3)
        size = '0;
      else if (pick < 65)
        size = REQ_W'($urandom_range(1, 128));
      else if (pick < 85)
        size = REQ_W'($urandom_range(129, 1024));
      else if (pick < 95)
        size = REQ_W'($urandom_range(1025, 8192));
      else
        size = REQ_W'($urandom_range(8193, (1 << REQ_W) - 1));
    end else if (roll < 90 && n_live != 0) begin
      offset = FADDR_W'(ledger.live_offsets[$urandom_range(0, n_live - 1)]);
    end else if (pick < 40 && n_freed != 0) begin
      offset = FADDR_W'(ledger.freed_offsets[$urandom_range(0, n_freed - 1)]);
    end else if (pick < 75 && n_live != 0) begin
      offset = FADDR_W'(ledger.live_offsets[$urandom_range(0, n_live - 1)]
                        + 8 * $urandom_range(1, 4));
    end
  endfunction

  // Every reply taken by the receiver is checked at the edge that moves it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      ledger.check_result(out_tdata[RES_ADDR_W-1:0], out_tuser);
  end

  // Receiver: it switches between stall patterns at random,
  // including stretches with no stall at all. Once, after enough replies,
  // it holds off for a long stretch while the sender keeps offering, so the
  // output register fills and the block has to stall its input.
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        if (!held && ledger.replies_seen >= HOLD_AT) begin
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          RX_OPEN:       out_tready <= 1'b1;
          RX_HALF:       out_tready <= 1'($urandom_range(0, 1));
          RX_RARE_STALL: out_tready <= ($urandom_range(0, 7) != 0);
          default:       out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    ffha_op_t           op;
    logic [REQ_W-1:0]   size;
    logic [FADDR_W-1:0] offset;
    int unsigned        sent;
    int unsigned        burst;
    ledger = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the single free block of the reset state.
    send_request(OP_ALLOC, '0, '0);               // zero size
    send_request(OP_ALLOC, '1, '0);               // largest size field, no fit
    send_request(OP_ALLOC, 14'd8177, '0);         // rounds past the heap, no fit
    send_request(OP_ALLOC, 14'd8176, '0);         // exact fit of the whole heap
    send_request(OP_FREE, '0, 13'd16);
    pause_input($urandom_range(0, 3));
    send_request(OP_FREE, '0, 13'd16);            // double free
    send_request(OP_FREE, '0, '0);                // header offset, not a payload
    send_request(OP_ALLOC, 14'd8150, '0);         // leftover too small to split
    send_request(OP_FREE, '0, '1);                // offset past every block
    send_request(OP_FREE, '0, 13'd16);
    send_request(OP_ALLOC, 14'd1, '0);            // split from here on
    send_request(OP_ALLOC, 14'd24, '0);
    pause_input($urandom_range(0, 3));
    send_request(OP_ALLOC, 14'd8, '0);
    send_request(OP_FREE, '0, 13'd16);
    send_request(OP_FREE, '0, 13'd40);            // free block lies before it
    send_request(OP_FREE, '0, 13'd44);            // inside a block
    send_request(OP_ALLOC, 14'd32, '0);           // walk merges the two free blocks
    send_request(OP_ALLOC, 14'd5000, '0);
    send_request(OP_ALLOC, 14'd3000, '0);
    send_request(OP_FREE, '0, 13'd80);
    send_request(OP_ALLOC, 14'd8192, '0);
    send_request(OP_FREE, '0, 13'd16);
    drain_results();

    // Random part: bursts of requests with random gaps, some without gaps.
    // Halfway through, the sender waits until the block has answered all.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < RAND_ITEMS) begin
        pick_request(op, size, offset);
        send_request(op, size, offset);
        sent++;
        burst--;
        if (sent == RAND_ITEMS / 2) drain_results();
      end
      pause_input(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A correct run takes a small fraction of this; only a hang reaches it.
  initial begin : watchdog
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_hdr_ram.sv
sv/first_fit_heap_allocator.sv
sv/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
